FILE: rtl/core/touch_point_calibrate_map_macros.svh
// Assertion macros shared by the touch point calibrate map checkers.
`ifndef TOUCH_POINT_CALIBRATE_MAP_MACROS_SVH
`define TOUCH_POINT_CALIBRATE_MAP_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define TPCM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define TPCM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: rtl/core/tpcm_pkg.sv
// Types and constants shared by the touch point calibrate map modules.
`default_nettype none

package tpcm_pkg;

    localparam int COORD_W          = 12;
    localparam int PROD_W           = 2 * COORD_W;
    localparam int DIV_STEPS_PER_CYC = 2;
    localparam int DIV_CYCLES       = COORD_W / DIV_STEPS_PER_CYC;
    localparam int DIV_CNT_W        = $clog2(DIV_CYCLES);

    typedef logic [COORD_W-1:0] coord_t;

    localparam coord_t CAL_X_LOW_RST  = 12'd1;
    localparam coord_t CAL_X_HIGH_RST = 12'd239;
    localparam coord_t CAL_Y_LOW_RST  = 12'd6;
    localparam coord_t CAL_Y_HIGH_RST = 12'd298;
    localparam coord_t TX_DEFAULT     = 12'd239;
    localparam coord_t TY_DEFAULT     = 12'd319;
    localparam logic [3:0] MIN_COUNT    = 4'd1;
    localparam logic [3:0] MAX_COUNT    = 4'd5;
    localparam logic [3:0] STATUS_TOUCH = 4'h6;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    localparam rot_t ROTATION_RST = ROT_90;

    typedef enum logic [2:0] {
        REG_DEVICE_PRESENT = 3'd0,
        REG_ROTATION       = 3'd1,
        REG_PANEL_X_MAX    = 3'd2,
        REG_PANEL_Y_MAX    = 3'd3,
        REG_DISP_WIDTH     = 3'd4,
        REG_DISP_HEIGHT    = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_NORM_X  = 2'd0,
        OP_NORM_Y  = 2'd1,
        OP_SCALE_X = 2'd2,
        OP_SCALE_Y = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_EVAL  = 3'd1,
        ST_SETUP = 3'd2,
        ST_START = 3'd3,
        ST_WAIT  = 3'd4,
        ST_STORE = 3'd5,
        ST_OUT   = 3'd6
    } state_t;

    typedef struct packed {
        logic   device_present;
        rot_t   rotation;
        coord_t panel_x_max;
        coord_t panel_y_max;
        coord_t disp_width;
        coord_t disp_height;
    } cfg_t;

    typedef struct packed {
        logic       read_ok;
        logic [3:0] touch_count;
        logic [7:0] status_byte;
        logic [7:0] x_high;
        logic [7:0] y_high;
        logic [7:0] low_nibbles;
    } item_t;

    typedef struct packed {
        logic load;
        logic cal_upd;
        logic setup;
        logic div_start;
        logic store;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic pressed;
        logic bypass;
        logic geom_known;
        logic div_done;
    } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/tpcm_div.sv
// Iterative restoring divider, two quotient bits per cycle, 12-bit quotient.
`default_nettype none

module tpcm_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [tpcm_pkg::PROD_W-1:0]  dividend,
    input  wire tpcm_pkg::coord_t             divisor,
    output tpcm_pkg::coord_t                  quotient,
    output logic                              done
);

    localparam int CW = tpcm_pkg::COORD_W;

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [tpcm_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    tpcm_pkg::coord_t                 rem_reg, rem_next;
    tpcm_pkg::coord_t                 quo_reg, quo_next;
    tpcm_pkg::coord_t                 rem_v, quo_v;
    logic [CW:0]                      trial;
    logic                             ge;

    // The caller guarantees the quotient fits in 12 bits, so the upper half of
    // the dividend is already below the divisor and only 12 steps are needed.
    always_comb begin
        rem_v = rem_reg;
        quo_v = quo_reg;
        trial = '0;
        ge    = 1'b0;
        for (int i = 0; i < tpcm_pkg::DIV_STEPS_PER_CYC; i++) begin
            trial = {rem_v, quo_v[CW-1]};
            ge    = (trial >= {1'b0, divisor});
            if (ge) begin
                rem_v = CW'(trial - {1'b0, divisor});
            end else begin
                rem_v = trial[CW-1:0];
            end
            quo_v = {quo_v[CW-2:0], ge};
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = dividend[tpcm_pkg::PROD_W-1:CW];
            quo_next  = dividend[CW-1:0];
        end else if (busy_reg) begin
            rem_next = rem_v;
            quo_next = quo_v;
            if (cnt_reg == tpcm_pkg::DIV_CNT_W'(tpcm_pkg::DIV_CYCLES - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

FILE: rtl/core/tpcm_dp.sv
// Datapath: raw point capture, calibration window, operand setup, divider and results.
`default_nettype none

module tpcm_dp (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire tpcm_pkg::cfg_t   cfg,
    input  wire tpcm_pkg::item_t  item,
    input  wire tpcm_pkg::cmd_t   cmd,
    output tpcm_pkg::sts_t        sts,
    output logic                  res_pressed,
    output tpcm_pkg::coord_t      res_x,
    output tpcm_pkg::coord_t      res_y
);

    localparam int PW = tpcm_pkg::PROD_W;

    logic             pressed_reg, pressed_next;
    tpcm_pkg::coord_t xr_reg, xr_next, yr_reg, yr_next;
    tpcm_pkg::coord_t cal_x_low_reg, cal_x_low_next, cal_x_high_reg, cal_x_high_next;
    tpcm_pkg::coord_t cal_y_low_reg, cal_y_low_next, cal_y_high_reg, cal_y_high_next;
    tpcm_pkg::coord_t nx_reg, nx_next, ny_reg, ny_next;
    tpcm_pkg::coord_t dx_reg, dx_next, dy_reg, dy_next;
    logic [PW-1:0]    prod_reg, prod_next;
    tpcm_pkg::coord_t den_reg, den_next, bval_reg, bval_next, lim_reg, lim_next;
    logic             byp_reg, byp_next;

    logic             press_now, count_hit, status_hit, geom_known;
    tpcm_pkg::coord_t tx, ty, rx, ry, rw, rh;
    tpcm_pkg::coord_t num, mulf, den, bval, lim, val, res;
    logic             byp;
    tpcm_pkg::coord_t quotient;
    logic             div_done;

    assign count_hit  = (item.touch_count >= tpcm_pkg::MIN_COUNT) &&
                        (item.touch_count <= tpcm_pkg::MAX_COUNT);
    assign status_hit = (item.status_byte[3:0] == tpcm_pkg::STATUS_TOUCH);
    assign press_now  = cfg.device_present && item.read_ok && (count_hit || status_hit);

    assign geom_known = (cfg.panel_x_max != '0) && (cfg.panel_y_max != '0) &&
                        (cfg.disp_width != '0) && (cfg.disp_height != '0);

    // Normalize targets fall back to the display size, then to fixed defaults.
    always_comb begin
        if (cfg.panel_x_max != '0) begin
            tx = cfg.panel_x_max - 1'b1;
        end else if (cfg.disp_width != '0) begin
            tx = cfg.disp_width - 1'b1;
        end else begin
            tx = tpcm_pkg::TX_DEFAULT;
        end
        if (cfg.panel_y_max != '0) begin
            ty = cfg.panel_y_max - 1'b1;
        end else if (cfg.disp_height != '0) begin
            ty = cfg.disp_height - 1'b1;
        end else begin
            ty = tpcm_pkg::TY_DEFAULT;
        end
    end

    always_comb begin
        case (cfg.rotation)
            tpcm_pkg::ROT_0: begin
                rx = nx_reg;
                ry = ny_reg;
                rw = cfg.panel_x_max;
                rh = cfg.panel_y_max;
            end
            tpcm_pkg::ROT_90: begin
                rx = ny_reg;
                ry = cfg.panel_x_max - 1'b1 - nx_reg;
                rw = cfg.panel_y_max;
                rh = cfg.panel_x_max;
            end
            tpcm_pkg::ROT_180: begin
                rx = cfg.panel_x_max - 1'b1 - nx_reg;
                ry = cfg.panel_y_max - 1'b1 - ny_reg;
                rw = cfg.panel_x_max;
                rh = cfg.panel_y_max;
            end
            default: begin
                rx = cfg.panel_y_max - 1'b1 - ny_reg;
                ry = nx_reg;
                rw = cfg.panel_y_max;
                rh = cfg.panel_x_max;
            end
        endcase
    end

    // Operands for the current operation. Bypass means no division is needed.
    always_comb begin
        case (cmd.op)
            tpcm_pkg::OP_NORM_X: begin
                num  = xr_reg - cal_x_low_reg;
                mulf = tx;
                den  = cal_x_high_reg - cal_x_low_reg;
                byp  = ({1'b0, cal_x_high_reg} <= ({1'b0, cal_x_low_reg} + 13'd1));
                bval = '0;
                lim  = tx;
            end
            tpcm_pkg::OP_NORM_Y: begin
                num  = yr_reg - cal_y_low_reg;
                mulf = ty;
                den  = cal_y_high_reg - cal_y_low_reg;
                byp  = ({1'b0, cal_y_high_reg} <= ({1'b0, cal_y_low_reg} + 13'd1));
                bval = '0;
                lim  = ty;
            end
            tpcm_pkg::OP_SCALE_X: begin
                num  = rx;
                mulf = cfg.disp_width - 1'b1;
                den  = rw - 1'b1;
                byp  = !((rw > 12'd1) && (cfg.disp_width > 12'd1) && (rw != cfg.disp_width));
                bval = rx;
                lim  = cfg.disp_width - 1'b1;
            end
            default: begin
                num  = ry;
                mulf = cfg.disp_height - 1'b1;
                den  = rh - 1'b1;
                byp  = !((rh > 12'd1) && (cfg.disp_height > 12'd1) && (rh != cfg.disp_height));
                bval = ry;
                lim  = cfg.disp_height - 1'b1;
            end
        endcase
    end

    assign val = byp_reg ? bval_reg : quotient;
    assign res = (val > lim_reg) ? lim_reg : val;

    always_comb begin
        pressed_next    = pressed_reg;
        xr_next         = xr_reg;
        yr_next         = yr_reg;
        cal_x_low_next  = cal_x_low_reg;
        cal_x_high_next = cal_x_high_reg;
        cal_y_low_next  = cal_y_low_reg;
        cal_y_high_next = cal_y_high_reg;
        nx_next         = nx_reg;
        ny_next         = ny_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        prod_next       = prod_reg;
        den_next        = den_reg;
        byp_next        = byp_reg;
        bval_next       = bval_reg;
        lim_next        = lim_reg;
        if (cmd.load) begin
            pressed_next = press_now;
            xr_next      = {item.x_high, item.low_nibbles[7:4]};
            yr_next      = {item.y_high, item.low_nibbles[3:0]};
        end
        if (cmd.cal_upd) begin
            if (xr_reg < cal_x_low_reg)  cal_x_low_next  = xr_reg;
            if (xr_reg > cal_x_high_reg) cal_x_high_next = xr_reg;
            if (yr_reg < cal_y_low_reg)  cal_y_low_next  = yr_reg;
            if (yr_reg > cal_y_high_reg) cal_y_high_next = yr_reg;
        end
        if (cmd.setup) begin
            prod_next = PW'(num) * PW'(mulf);
            den_next  = den;
            byp_next  = byp;
            bval_next = bval;
            lim_next  = lim;
        end
        if (cmd.store) begin
            case (cmd.op)
                tpcm_pkg::OP_NORM_X: begin
                    nx_next = res;
                    dx_next = res;
                end
                tpcm_pkg::OP_NORM_Y: begin
                    ny_next = res;
                    dy_next = res;
                end
                tpcm_pkg::OP_SCALE_X: dx_next = res;
                default:              dy_next = res;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressed_reg    <= 1'b0;
            cal_x_low_reg  <= tpcm_pkg::CAL_X_LOW_RST;
            cal_x_high_reg <= tpcm_pkg::CAL_X_HIGH_RST;
            cal_y_low_reg  <= tpcm_pkg::CAL_Y_LOW_RST;
            cal_y_high_reg <= tpcm_pkg::CAL_Y_HIGH_RST;
        end else begin
            pressed_reg    <= pressed_next;
            cal_x_low_reg  <= cal_x_low_next;
            cal_x_high_reg <= cal_x_high_next;
            cal_y_low_reg  <= cal_y_low_next;
            cal_y_high_reg <= cal_y_high_next;
        end
    end

    always_ff @(posedge aclk) begin
        xr_reg   <= xr_next;
        yr_reg   <= yr_next;
        nx_reg   <= nx_next;
        ny_reg   <= ny_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        prod_reg <= prod_next;
        den_reg  <= den_next;
        byp_reg  <= byp_next;
        bval_reg <= bval_next;
        lim_reg  <= lim_next;
    end

    tpcm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    assign sts.pressed    = pressed_reg;
    assign sts.bypass     = byp_reg;
    assign sts.geom_known = geom_known;
    assign sts.div_done   = div_done;

    assign res_pressed = pressed_reg;
    assign res_x       = dx_reg;
    assign res_y       = dy_reg;

endmodule

`default_nettype wire

FILE: rtl/core/tpcm_ctrl.sv
// Controller: sequences capture, calibration, up to four divisions and the result handoff.
`default_nettype none

module tpcm_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    input  wire logic            out_free,
    input  wire tpcm_pkg::sts_t  sts,
    output logic                 in_ready,
    output logic                 emit,
    output tpcm_pkg::cmd_t       cmd
);

    tpcm_pkg::state_t state_reg, state_next;
    tpcm_pkg::op_t    op_reg, op_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tpcm_pkg::ST_IDLE;
            op_reg    <= tpcm_pkg::OP_NORM_X;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        in_ready   = 1'b0;
        emit       = 1'b0;
        case (state_reg)
            tpcm_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = tpcm_pkg::ST_EVAL;
                end
            end
            tpcm_pkg::ST_EVAL: begin
                if (sts.pressed) begin
                    cmd.cal_upd = 1'b1;
                    op_next     = tpcm_pkg::OP_NORM_X;
                    state_next  = tpcm_pkg::ST_SETUP;
                end else begin
                    state_next = tpcm_pkg::ST_OUT;
                end
            end
            tpcm_pkg::ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = tpcm_pkg::ST_START;
            end
            tpcm_pkg::ST_START: begin
                if (sts.bypass) begin
                    state_next = tpcm_pkg::ST_STORE;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = tpcm_pkg::ST_WAIT;
                end
            end
            tpcm_pkg::ST_WAIT: begin
                if (sts.div_done) begin
                    state_next = tpcm_pkg::ST_STORE;
                end
            end
            tpcm_pkg::ST_STORE: begin
                cmd.store = 1'b1;
                case (op_reg)
                    tpcm_pkg::OP_NORM_X: begin
                        op_next    = tpcm_pkg::OP_NORM_Y;
                        state_next = tpcm_pkg::ST_SETUP;
                    end
                    tpcm_pkg::OP_NORM_Y: begin
                        // Without full geometry the normalized point goes out as is.
                        if (sts.geom_known) begin
                            op_next    = tpcm_pkg::OP_SCALE_X;
                            state_next = tpcm_pkg::ST_SETUP;
                        end else begin
                            state_next = tpcm_pkg::ST_OUT;
                        end
                    end
                    tpcm_pkg::OP_SCALE_X: begin
                        op_next    = tpcm_pkg::OP_SCALE_Y;
                        state_next = tpcm_pkg::ST_SETUP;
                    end
                    default: begin
                        state_next = tpcm_pkg::ST_OUT;
                    end
                endcase
            end
            tpcm_pkg::ST_OUT: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = tpcm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tpcm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/touch_point_calibrate_map.sv
// Top level: register port, controller, datapath and the result output register.
//
// One touch-report snapshot enters on the s_ stream; one result leaves on the m_ stream.
// The s_ side takes a request only while no snapshot is in flight. A released sample
// passes from the evaluate state straight to the output state. A pressed sample updates
// the calibration window and runs four operations on one shared divider (X and Y
// normalize, then X and Y display scaling); each goes through setup, start, a wait for
// the divider and store, and skips the wait when no division is needed.
// Without full panel and display geometry the scaling pair is skipped.
// The next request can be taken in the cycle after the result is handed off.
// The divider produces two quotient bits per cycle.
// Results sit in an output register: the next snapshot is accepted while a result
// waits, and a stalled m_ side holds the finished result only once the following one
// is ready, freezing the block until m_tready returns.
// Synchronous active-low reset clears the configuration registers to their defaults
// (rotation 90), restores the calibration window and empties the output register.
// Configuration registers sit at byte addresses 4*i. The user must write them only
// while idle; the block itself does not enforce it.
`default_nettype none

module touch_point_calibrate_map (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Input snapshot stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [3:0] touch_count, [11:4] status_byte, [19:12] x_high, [27:20] y_high,
    // [35:28] low_nibbles, [39:36] zero
    input  wire logic [39:0] s_tdata,
    // [0] read_ok
    input  wire logic        s_tuser,
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [11:0] disp_x, [23:12] disp_y
    output logic [23:0]      m_tdata,
    // [0] touch_pressed
    output logic             m_tuser
);

    logic              device_present_reg, device_present_next;
    tpcm_pkg::rot_t    rotation_reg, rotation_next;
    tpcm_pkg::coord_t  panel_x_max_reg, panel_x_max_next;
    tpcm_pkg::coord_t  panel_y_max_reg, panel_y_max_next;
    tpcm_pkg::coord_t  disp_width_reg, disp_width_next;
    tpcm_pkg::coord_t  disp_height_reg, disp_height_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [23:0]       m_tdata_reg, m_tdata_next;
    logic              m_tuser_reg, m_tuser_next;

    logic              cfg_write;
    tpcm_pkg::reg_idx_t cfg_idx;
    tpcm_pkg::cfg_t    cfg;
    tpcm_pkg::item_t   item;
    tpcm_pkg::cmd_t    cmd;
    tpcm_pkg::sts_t    sts;
    logic              in_ready, emit, out_free;
    logic              res_pressed;
    tpcm_pkg::coord_t  res_x, res_y;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = tpcm_pkg::reg_idx_t'(paddr[4:2]);

    always_comb begin
        device_present_next = device_present_reg;
        rotation_next       = rotation_reg;
        panel_x_max_next    = panel_x_max_reg;
        panel_y_max_next    = panel_y_max_reg;
        disp_width_next     = disp_width_reg;
        disp_height_next    = disp_height_reg;
        if (cfg_write) begin
            case (cfg_idx)
                tpcm_pkg::REG_DEVICE_PRESENT: device_present_next = pwdata[0];
                tpcm_pkg::REG_ROTATION:       rotation_next = tpcm_pkg::rot_t'(pwdata[1:0]);
                tpcm_pkg::REG_PANEL_X_MAX:    panel_x_max_next = pwdata[11:0];
                tpcm_pkg::REG_PANEL_Y_MAX:    panel_y_max_next = pwdata[11:0];
                tpcm_pkg::REG_DISP_WIDTH:     disp_width_next = pwdata[11:0];
                tpcm_pkg::REG_DISP_HEIGHT:    disp_height_next = pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            tpcm_pkg::REG_DEVICE_PRESENT: prdata = {31'd0, device_present_reg};
            tpcm_pkg::REG_ROTATION:       prdata = {30'd0, rotation_reg};
            tpcm_pkg::REG_PANEL_X_MAX:    prdata = {20'd0, panel_x_max_reg};
            tpcm_pkg::REG_PANEL_Y_MAX:    prdata = {20'd0, panel_y_max_reg};
            tpcm_pkg::REG_DISP_WIDTH:     prdata = {20'd0, disp_width_reg};
            tpcm_pkg::REG_DISP_HEIGHT:    prdata = {20'd0, disp_height_reg};
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_present_reg <= 1'b0;
            rotation_reg       <= tpcm_pkg::ROTATION_RST;
            panel_x_max_reg    <= '0;
            panel_y_max_reg    <= '0;
            disp_width_reg     <= '0;
            disp_height_reg    <= '0;
        end else begin
            device_present_reg <= device_present_next;
            rotation_reg       <= rotation_next;
            panel_x_max_reg    <= panel_x_max_next;
            panel_y_max_reg    <= panel_y_max_next;
            disp_width_reg     <= disp_width_next;
            disp_height_reg    <= disp_height_next;
        end
    end

    assign cfg.device_present = device_present_reg;
    assign cfg.rotation       = rotation_reg;
    assign cfg.panel_x_max    = panel_x_max_reg;
    assign cfg.panel_y_max    = panel_y_max_reg;
    assign cfg.disp_width     = disp_width_reg;
    assign cfg.disp_height    = disp_height_reg;

    assign item.read_ok     = s_tuser;
    assign item.touch_count = s_tdata[3:0];
    assign item.status_byte = s_tdata[11:4];
    assign item.x_high      = s_tdata[19:12];
    assign item.y_high      = s_tdata[27:20];
    assign item.low_nibbles = s_tdata[35:28];

    assign s_tready = in_ready;
    assign out_free = !m_tvalid_reg || m_tready;

    tpcm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .sts      (sts),
        .in_ready (in_ready),
        .emit     (emit),
        .cmd      (cmd)
    );

    tpcm_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .item        (item),
        .cmd         (cmd),
        .sts         (sts),
        .res_pressed (res_pressed),
        .res_x       (res_x),
        .res_y       (res_y)
    );

    // A released sample always reports a zero point.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = res_pressed;
            m_tdata_next  = res_pressed ? {res_y, res_x} : '0;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

FILE: rtl/core/tpcm_checker.sv
// Port-level checker for the touch point calibrate map, bound to the top level.
`default_nettype none
`include "touch_point_calibrate_map_macros.svh"

module tpcm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tuser
);

    `TPCM_ASSERT_ALWAYS(a_reset_empties_out, !aresetn |=> !m_tvalid, "output valid after reset")

    `TPCM_ASSERT(a_one_in_flight, (s_tvalid && s_tready) |=> !s_tready, "request taken while busy")

    `TPCM_ASSERT(a_released_zero, (m_tvalid && !m_tuser) |-> (m_tdata == 24'd0), "released point not zero")

    `TPCM_ASSERT(a_stall_holds, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")

endmodule

bind touch_point_calibrate_map tpcm_checker u_tpcm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
